// ----- rtl/core/rsst_pkg.sv -----
package rsst_pkg;

  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic descend;
    logic leaf_write;
    logic sib_read;
    logic parent_write;
    logic query_step;
    logic result_load;
  } rsst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic at_leaf;
    logic at_root;
    logic near_root;
    logic range_empty;
    logic query_last;
  } rsst_status_t;

endpackage

// ----- rtl/core/range_sum_segment_tree.sv -----
// Segment tree of 32-bit wrapping sums over element_count elements, kept in a
// single-port node store of 4*MAX_ELEMENTS words with one registered read and
// one write per cycle. After reset the block zeroes every word of the store
// and takes no item meanwhile; configuration writes are taken at any time.
// Items are handled one at a time. A write descends one level at a time to
// the leaf and writes it, then climbs with a sibling read and a parent write
// per level, both through the one memory port. A query visits nodes one at a
// time, deferring right children on a stack; a range that is empty after
// clipping skips the walk. A result waits in an output register, so the next
// item may be accepted while it is still stalled.
module range_sum_segment_tree
  import rsst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [COUNT_W-1:0]        cfg_write_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  write_value,
  input  logic [POS_W-1:0]          range_low,
  input  logic [POS_W-1:0]          range_high,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [DATA_W-1:0]  range_total
);

  rsst_cmd_t    cmd;
  rsst_status_t status;

  rsst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  rsst_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .kind           (kind),
    .position       (position),
    .write_value    (write_value),
    .range_low      (range_low),
    .range_high     (range_high),
    .range_total    (range_total)
  );

endmodule

// ----- rtl/core/rsst_datapath.sv -----
module rsst_datapath
  import rsst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rsst_cmd_t                 cmd,
  output rsst_status_t              status,
  input  logic                      cfg_write_en,
  input  logic [COUNT_W-1:0]        cfg_write_data,
  input  logic                      kind,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  write_value,
  input  logic [POS_W-1:0]          range_low,
  input  logic [POS_W-1:0]          range_high,
  output logic signed [DATA_W-1:0]  range_total
);

  localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
  localparam int NW         = $clog2(NODE_DEPTH);
  localparam int SD         = $clog2(MAX_ELEMENTS) + 1;
  localparam int SIW        = $clog2(SD);
  localparam int SPW        = $clog2(SD + 1);
  localparam logic [COUNT_W-1:0] MAX_LAST  = COUNT_W'(MAX_ELEMENTS - 1);
  localparam logic [NW-1:0]      CLR_LAST  = NW'(NODE_DEPTH - 1);

  logic [COUNT_W-1:0] element_count;
  logic [COUNT_W-1:0] last_idx;

  logic [DATA_W-1:0] mem [NODE_DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              rd_pending;
  logic [NW-1:0]     clr_addr;

  logic               kind_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   wlo;
  logic [COUNT_W-1:0] whi;
  logic [NW-1:0]      node;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [DATA_W-1:0]  carry;
  logic [DATA_W-1:0]  acc;

  logic [NW-1:0]      stk_node [SD];
  logic [COUNT_W-1:0] stk_lo   [SD];
  logic [COUNT_W-1:0] stk_hi   [SD];
  logic [SPW-1:0]     sp;
  logic [SPW-1:0]     sp_dec;

  logic [COUNT_W:0]   mid_sum;
  logic [COUNT_W-1:0] mid;
  logic [NW-1:0]      left_child;
  logic [NW-1:0]      right_child;
  logic [NW-1:0]      parent;
  logic [NW-1:0]      sibling;
  logic [COUNT_W-1:0] wlo_ext;
  logic [COUNT_W-1:0] pos_ext;
  logic [COUNT_W-1:0] range_high_ext;
  logic               disjoint;
  logic               covered;
  logic               visit_ends;
  logic [DATA_W-1:0]  parent_sum;

  logic               wr_en;
  logic [NW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic               rd_en;
  logic [NW-1:0]      rd_addr;

  // A count of zero acts as one; a count above the tree size saturates.
  always_comb begin
    if (element_count == '0) begin
      last_idx = '0;
    end else if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
      last_idx = MAX_LAST;
    end else begin
      last_idx = element_count - 1'b1;
    end
  end

  assign mid_sum        = {1'b0, lo} + {1'b0, hi};
  assign mid            = mid_sum[COUNT_W:1];
  assign left_child     = {node[NW-2:0], 1'b0} + NW'(1);
  assign right_child    = {node[NW-2:0], 1'b0} + NW'(2);
  assign parent         = (node - NW'(1)) >> 1;
  assign sibling        = node[0] ? node + NW'(1) : node - NW'(1);
  assign wlo_ext        = COUNT_W'(wlo);
  assign pos_ext        = COUNT_W'(pos_q);
  assign range_high_ext = COUNT_W'(range_high);
  assign disjoint       = (whi < lo) || (wlo_ext > hi);
  assign covered        = (wlo_ext <= lo) && (hi <= whi);
  assign visit_ends     = disjoint || covered;
  assign parent_sum     = carry + mem_q;
  assign sp_dec         = sp - SPW'(1);

  assign status.clear_last  = (clr_addr == CLR_LAST);
  assign status.is_query    = (kind_q == KIND_QUERY);
  assign status.at_leaf     = (lo == hi);
  assign status.at_root     = (node == '0);
  assign status.near_root   = (node == NW'(1)) || (node == NW'(2));
  assign status.range_empty = (wlo_ext > whi);
  assign status.query_last  = visit_ends && (sp == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = carry;
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.leaf_write) begin
      wr_en   = 1'b1;
    end else if (cmd.parent_write) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = parent_sum;
    end
  end

  assign rd_en   = cmd.sib_read || (cmd.query_step && covered);
  assign rd_addr = cmd.sib_read ? sibling : node;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
      clr_addr      <= '0;
      rd_pending    <= 1'b0;
      sp            <= '0;
    end else begin
      if (cfg_write_en) begin
        element_count <= cfg_write_data;
      end
      if (cmd.clear_en) begin
        clr_addr <= clr_addr + NW'(1);
      end
      rd_pending <= cmd.query_step && covered;
      if (cmd.load) begin
        sp <= '0;
      end else if (cmd.query_step) begin
        if (visit_ends) begin
          if (sp != '0) begin
            sp <= sp_dec;
          end
        end else begin
          sp <= sp + SPW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      pos_q  <= position;
      carry  <= write_value;
      wlo    <= range_low;
      whi    <= (range_high_ext > last_idx) ? last_idx : range_high_ext;
      node   <= '0;
      lo     <= '0;
      hi     <= last_idx;
      acc    <= '0;
    end else begin
      if (rd_pending) begin
        acc <= acc + mem_q;
      end
      if (cmd.descend) begin
        if (pos_ext <= mid) begin
          node <= left_child;
          hi   <= mid;
        end else begin
          node <= right_child;
          lo   <= mid + 1'b1;
        end
      end
      if (cmd.parent_write) begin
        node  <= parent;
        carry <= parent_sum;
      end
      if (cmd.query_step) begin
        if (visit_ends) begin
          // Resume with the deepest deferred right child, if any.
          if (sp != '0) begin
            node <= stk_node[sp_dec[SIW-1:0]];
            lo   <= stk_lo[sp_dec[SIW-1:0]];
            hi   <= stk_hi[sp_dec[SIW-1:0]];
          end
        end else begin
          stk_node[sp[SIW-1:0]] <= right_child;
          stk_lo[sp[SIW-1:0]]   <= mid + 1'b1;
          stk_hi[sp[SIW-1:0]]   <= hi;
          node <= left_child;
          hi   <= mid;
        end
      end
    end
    if (cmd.result_load) begin
      range_total <= acc;
    end
  end

  a_stack_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.query_step && !visit_ends) |-> (32'(sp) < SD))
    else $error("query stack overflow");

  a_read_follows_step: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> $past(cmd.query_step))
    else $error("accumulate without a covered node read");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (32'(wr_addr) < NODE_DEPTH))
    else $error("node write outside the store");

endmodule

// ----- rtl/core/rsst_ctrl.sv -----
module rsst_ctrl
  import rsst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  output logic         result_valid,
  input  logic         result_stall,
  input  rsst_status_t status,
  output rsst_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_DESCEND,
    ST_SIB_READ,
    ST_PARENT,
    ST_QUERY,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (!status.is_query) begin
          state_next = ST_DESCEND;
        end else if (status.range_empty) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_QUERY;
        end
      end
      ST_DESCEND: begin
        if (status.at_leaf) begin
          cmd.leaf_write = 1'b1;
          state_next = status.at_root ? ST_FINISH : ST_SIB_READ;
        end else begin
          cmd.descend = 1'b1;
        end
      end
      ST_SIB_READ: begin
        cmd.sib_read = 1'b1;
        state_next   = ST_PARENT;
      end
      ST_PARENT: begin
        cmd.parent_write = 1'b1;
        state_next = status.near_root ? ST_FINISH : ST_SIB_READ;
      end
      ST_QUERY: begin
        cmd.query_step = 1'b1;
        if (status.query_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last node read lands in the accumulator during this cycle.
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.result_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> result_valid)
    else $error("result not presented after load");

endmodule
